FILE: hdl/six_axis_normalizer_with_grip_latch_top_macros.svh
// Assertion macros for the six-axis normalizer.
// Included by the top level; relies on its clock and reset names.
`ifndef SIX_AXIS_NORMALIZER_WITH_GRIP_LATCH_TOP_MACROS_SVH
`define SIX_AXIS_NORMALIZER_WITH_GRIP_LATCH_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SANZ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define SANZ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sanz_pkg.sv
// Shared constants, types and codes for the six-axis normalizer.
// No dependencies; used by every module of the block.
`default_nettype none

package sanz_pkg;

  // Field widths
  localparam int unsigned RAW_WIDTH      = 16;
  localparam int unsigned OUT_W          = 16;
  localparam int unsigned OUT_AXES       = 6;
  localparam int unsigned AXIS_COUNT_DEF = 6;
  localparam int unsigned SRC_W          = 3;
  localparam int unsigned DIV_W          = 16;
  localparam int unsigned FRAC_BITS      = 14;
  localparam int unsigned Q_W            = 15;
  localparam int unsigned DZ_W           = 15;
  localparam int unsigned BTN_W          = 32;
  localparam int unsigned TS_W           = 48;
  localparam int unsigned IN_DATA_W      = 176;
  localparam int unsigned OUT_DATA_W     = 184;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned MAP_W      = SRC_W * OUT_AXES;
  localparam int unsigned SCALE_W    = DIV_W * 3;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MAP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEGATE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_TRANS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_ROT   = 3'd4;

  // Identity source map: output axis k reads source axis k
  localparam logic [MAP_W-1:0] MAP_RESET = 18'd181896;

  // 1.0 in Q2.14
  localparam logic [Q_W-1:0] ONE_Q14 = 15'd16384;

  // Commands and result kinds
  localparam logic CMD_RAW   = 1'b0;
  localparam logic CMD_TICK  = 1'b1;
  localparam logic KIND_RAW  = 1'b0;
  localparam logic KIND_NORM = 1'b1;

  // Grip button positions in the button mask
  localparam int unsigned GRIP_CLOSE = 0;
  localparam int unsigned GRIP_OPEN  = 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_START,
    ST_DIV,
    ST_NORM,
    ST_RAW
  } state_e;

  // Broadcast from the top level to every lane
  typedef struct packed {
    logic                   load;
    logic [SRC_W-1:0]       sel;
    logic [RAW_WIDTH-1:0]   raw;
    logic                   start;
  } lane_cmd_t;

  // Lane status back to the merge stage
  typedef struct packed {
    logic             busy;
    logic [OUT_W-1:0] value;
  } lane_stat_t;

endpackage

`default_nettype wire

FILE: hdl/sanz_lane.sv
// One normalization lane: source capture, bit-serial divider, saturate, deadzone.
// Depends on sanz_pkg.
`default_nettype none

module sanz_lane #(
  parameter int unsigned AXIS_N = sanz_pkg::AXIS_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sanz_pkg::lane_cmd_t         cmd_i,
  input  logic [sanz_pkg::SRC_W-1:0]  src_i,
  input  logic [sanz_pkg::DIV_W-1:0]  divisor_i,
  input  logic                        negate_i,
  input  logic [sanz_pkg::DZ_W-1:0]   deadzone_i,
  output sanz_pkg::lane_stat_t        stat_o
);
  import sanz_pkg::*;

  localparam int unsigned DVD_W = RAW_WIDTH + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic [RAW_WIDTH-1:0] raw_q;
  logic                 mapped_q;
  logic                 neg_q;
  logic [DIV_W-1:0]     rem_q, rem_d;
  logic [DVD_W-1:0]     quo_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q;

  logic [RAW_WIDTH-1:0] mag;
  logic [DIV_W-1:0]     div_eff;
  logic [DIV_W:0]       trial, diff;
  logic                 ge;
  logic [Q_W-1:0]       q_sat, q_keep;
  logic [OUT_W-1:0]     pos_val;

  // Magnitude of the captured axis; the most negative code maps to 2^(w-1)
  assign mag     = raw_q[RAW_WIDTH-1] ? RAW_WIDTH'(~raw_q + 1'b1) : raw_q;
  assign div_eff = (divisor_i == '0) ? DIV_W'(1) : divisor_i;

  // One restoring-division step per cycle
  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign diff  = trial - {1'b0, div_eff};
  assign ge    = (trial >= {1'b0, div_eff});
  assign rem_d = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

  // Saturate to 1.0, then deadzone, then sign
  assign q_sat   = (quo_q > DVD_W'(ONE_Q14)) ? ONE_Q14 : quo_q[Q_W-1:0];
  assign q_keep  = (!mapped_q || (q_sat < deadzone_i)) ? '0 : q_sat;
  assign pos_val = {1'b0, q_keep};

  assign stat_o.busy  = busy_q;
  assign stat_o.value = neg_q ? OUT_W'(-pos_val) : pos_val;

  // Divider control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: capture on matching broadcast, load on start, shift while busy
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (cmd_i.sel == src_i)) begin
      raw_q <= cmd_i.raw;
    end
    if (cmd_i.start) begin
      neg_q    <= raw_q[RAW_WIDTH-1] ^ negate_i;
      mapped_q <= ({1'b0, src_i} < (SRC_W + 1)'(AXIS_N));
      quo_q    <= {mag, FRAC_BITS'(0)};
      rem_q    <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sanz_grip.sv
// Gripper latch driven by single rising edges of the close and open buttons.
// Depends on sanz_pkg.
`default_nettype none

module sanz_grip (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       update_i,
  input  logic [1:0] buttons_i,
  output logic       grip_o
);
  import sanz_pkg::*;

  logic [1:0] prior_q;
  logic       grip_q, grip_d;
  logic [1:0] rising;
  logic       close_rise, open_rise, both_held;

  assign rising     = buttons_i & ~prior_q;
  assign close_rise = rising[GRIP_CLOSE];
  assign open_rise  = rising[GRIP_OPEN];
  assign both_held  = buttons_i[GRIP_CLOSE] & buttons_i[GRIP_OPEN];

  // Edges count only when exactly one fires and not both are held
  always_comb begin
    grip_d = grip_q;
    if (!both_held && (close_rise != open_rise)) begin
      grip_d = close_rise;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q <= '0;
      grip_q  <= 1'b0;
    end else if (update_i) begin
      prior_q <= buttons_i;
      grip_q  <= grip_d;
    end
  end

  assign grip_o = grip_q;

endmodule

`default_nettype wire

FILE: hdl/six_axis_normalizer_with_grip_latch_top.sv
// Six-axis controller normalizer top: report store, lane array, merge and output register.
// Depends on sanz_pkg, sanz_lane, sanz_grip and the assertion macro header.
//
// A raw report (tuser 0) updates the held axes, buttons and gripper latch and
// yields one raw beat, loaded into the output register once that register is
// free; the input is ready again when the raw beat is loaded. A tick (tuser 1)
// yields a normalized beat then a raw beat: the held axes are broadcast to the
// lanes one source per cycle, then every lane runs a one-bit-per-cycle divider
// of RAW_WIDTH+14 steps; the normalized beat is loaded once no lane is busy and
// the output register is free, then the raw beat likewise, and the input is
// ready again when the raw beat is loaded. A new beat is accepted whenever the
// control is idle, even while the last result still waits in the output
// register.
`default_nettype none

module six_axis_normalizer_with_grip_latch_top #(
  parameter int unsigned AXIS_COUNT = sanz_pkg::AXIS_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata, LSB up: raw_axis_0..raw_axis_5, button_bits, time_stamp
  input  logic [sanz_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: command
  input  logic                              s_axis_tuser,
  // Output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata, LSB up: out_axis_0..out_axis_5, held_buttons, grip_closed,
  // sample_time, zero pad
  output logic [sanz_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // tuser: result_kind
  output logic                              m_axis_tuser,
  // tlast: last_of_run
  output logic                              m_axis_tlast,
  // Configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sanz_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sanz_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import sanz_pkg::*;

  `include "six_axis_normalizer_with_grip_latch_top_macros.svh"

  localparam int unsigned AXIS_N = (AXIS_COUNT < OUT_AXES) ? AXIS_COUNT : OUT_AXES;
  localparam int unsigned SEL_W  = (AXIS_N > 1) ? $clog2(AXIS_N) : 1;
  localparam int unsigned PAD_W  = OUT_DATA_W - (OUT_AXES * OUT_W + BTN_W + 1 + TS_W);

  // Configuration registers
  logic [MAP_W-1:0]    map_q;
  logic [OUT_AXES-1:0] negate_q;
  logic [DZ_W-1:0]     deadzone_q;
  logic [SCALE_W-1:0]  scale_trans_q;
  logic [SCALE_W-1:0]  scale_rot_q;

  // Held report
  logic [RAW_WIDTH-1:0] held_axes_q [AXIS_N];
  logic [BTN_W-1:0]     held_btn_q;
  logic [TS_W-1:0]      time_q;
  logic                 grip;

  // Control
  state_e           state_q, state_d;
  logic [SEL_W-1:0] sel_q;
  logic             in_accept;
  logic             in_tick;
  logic             out_free;
  logic             load_norm, load_raw;
  logic             lane_load, lane_start;
  logic             any_busy;

  // Output register
  logic                            out_valid_q;
  logic                            out_kind_q;
  logic                            out_last_q;
  logic [OUT_AXES-1:0][OUT_W-1:0]  out_axes_q;
  logic [BTN_W-1:0]                out_btn_q;
  logic                            out_grip_q;
  logic [TS_W-1:0]                 out_time_q;

  logic [OUT_AXES-1:0][OUT_W-1:0]  norm_axes;
  logic [OUT_AXES-1:0][OUT_W-1:0]  raw_axes;
  logic [AXIS_N-1:0]               lane_busy;
  lane_cmd_t                       lane_cmd;

  assign in_accept = s_axis_tvalid & s_axis_tready;
  assign in_tick   = (s_axis_tuser == CMD_TICK);
  assign out_free  = !out_valid_q || m_axis_tready;
  assign any_busy  = |lane_busy;
  assign cfg_ready_o = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q         <= MAP_RESET;
      negate_q      <= '0;
      deadzone_q    <= '0;
      scale_trans_q <= '0;
      scale_rot_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SOURCE_MAP:  map_q         <= cfg_data_i[MAP_W-1:0];
        REG_NEGATE:      negate_q      <= cfg_data_i[OUT_AXES-1:0];
        REG_DEADZONE:    deadzone_q    <= cfg_data_i[DZ_W-1:0];
        REG_SCALE_TRANS: scale_trans_q <= cfg_data_i[SCALE_W-1:0];
        REG_SCALE_ROT:   scale_rot_q   <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Report store: axes and buttons taken on a raw update beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < AXIS_N; k++) begin
        held_axes_q[k] <= '0;
      end
      held_btn_q <= '0;
    end else if (in_accept && (s_axis_tuser == CMD_RAW)) begin
      for (int k = 0; k < AXIS_N; k++) begin
        held_axes_q[k] <= s_axis_tdata[k*OUT_W +: RAW_WIDTH];
      end
      held_btn_q <= s_axis_tdata[OUT_AXES*OUT_W +: BTN_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      time_q <= s_axis_tdata[OUT_AXES*OUT_W + BTN_W +: TS_W];
    end
  end

  sanz_grip u_grip (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .update_i  (in_accept && (s_axis_tuser == CMD_RAW)),
    .buttons_i (s_axis_tdata[OUT_AXES*OUT_W +: 2]),
    .grip_o    (grip)
  );

  // Source broadcast counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0;
    end else if (state_q == ST_LOAD) begin
      sel_q <= sel_q + 1'b1;
    end else begin
      sel_q <= '0;
    end
  end

  assign lane_cmd.load  = lane_load;
  assign lane_cmd.sel   = SRC_W'(sel_q);
  assign lane_cmd.raw   = held_axes_q[sel_q];
  assign lane_cmd.start = lane_start;

  // Lane array
  for (genvar k = 0; k < OUT_AXES; k++) begin : g_lane
    if (k < AXIS_N) begin : g_on
      lane_stat_t       stat;
      logic [DIV_W-1:0] divisor;

      if (k < 3) begin : g_trans
        assign divisor = scale_trans_q[k*DIV_W +: DIV_W];
      end else begin : g_rot
        assign divisor = scale_rot_q[(k-3)*DIV_W +: DIV_W];
      end

      sanz_lane #(
        .AXIS_N (AXIS_N)
      ) u_lane (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .cmd_i      (lane_cmd),
        .src_i      (map_q[k*SRC_W +: SRC_W]),
        .divisor_i  (divisor),
        .negate_i   (negate_q[k]),
        .deadzone_i (deadzone_q),
        .stat_o     (stat)
      );

      assign lane_busy[k] = stat.busy;
      assign norm_axes[k] = stat.value;
      assign raw_axes[k]  = OUT_W'(held_axes_q[k]);
    end else begin : g_off
      assign norm_axes[k] = '0;
      assign raw_axes[k]  = '0;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_accept) state_d = in_tick ? ST_LOAD : ST_RAW;
      ST_LOAD:  if (sel_q == SEL_W'(AXIS_N - 1)) state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV:   if (!any_busy) state_d = ST_NORM;
      ST_NORM:  if (out_free) state_d = ST_RAW;
      ST_RAW:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    lane_load     = 1'b0;
    lane_start    = 1'b0;
    load_norm     = 1'b0;
    load_raw      = 1'b0;
    case (state_q)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_LOAD:  lane_load     = 1'b1;
      ST_START: lane_start    = 1'b1;
      ST_DIV:   ;
      ST_NORM:  load_norm     = out_free;
      ST_RAW:   load_raw      = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Merge into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_norm || load_raw) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_norm) begin
      out_kind_q <= KIND_NORM;
      out_last_q <= 1'b0;
      out_axes_q <= norm_axes;
      out_btn_q  <= '0;
      out_grip_q <= grip;
      out_time_q <= time_q;
    end else if (load_raw) begin
      out_kind_q <= KIND_RAW;
      out_last_q <= 1'b1;
      out_axes_q <= raw_axes;
      out_btn_q  <= held_btn_q;
      out_grip_q <= grip;
      out_time_q <= time_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {PAD_W'(0), out_time_q, out_grip_q, out_btn_q, out_axes_q};

  // Checks
  `SANZ_ASSERT_NOW(a_norm_not_last, m_axis_tvalid && (m_axis_tuser == KIND_NORM), !m_axis_tlast && (out_btn_q == '0), "normalized beat carries last or buttons")
  `SANZ_ASSERT_NOW(a_norm_after_div, load_norm, !any_busy, "normalized beat loaded while a lane divides")
  `SANZ_ASSERT_NEXT(a_tick_starts_load, in_accept && in_tick, (state_q == ST_LOAD) && !s_axis_tready, "tick did not start the source broadcast")

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the six-axis normalizer with gripper latch.
// Needs sanz_pkg and six_axis_normalizer_with_grip_latch_top; reports are
// predicted in SystemVerilog and every output beat is compared field by field.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sanz_pkg::*;

  localparam int unsigned AXES       = AXIS_COUNT_DEF;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned PHASES     = 9;
  localparam int unsigned PHASE_LEN  = 165;

  // One controller report or tick as it enters the block
  typedef struct packed {
    logic                 cmd;
    logic [5:0][15:0]     axes;
    logic [BTN_W-1:0]     buttons;
    logic [TS_W-1:0]      stamp;
  } report_t;

  // One output beat
  typedef struct packed {
    logic                 kind;
    logic [5:0][15:0]     axes;
    logic [BTN_W-1:0]     buttons;
    logic                 grip;
    logic [TS_W-1:0]      stamp;
    logic                 last;
  } sample_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [IN_DATA_W-1:0]   in_data = '0;
  logic                   in_user = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_data;
  logic                   out_user;
  logic                   out_last;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Predictor copy of the configuration registers
  logic [MAP_W-1:0]   map_reg   = MAP_RESET;
  logic [5:0]         neg_reg   = '0;
  logic [DZ_W-1:0]    dz_reg    = '0;
  logic [SCALE_W-1:0] trans_reg = '0;
  logic [SCALE_W-1:0] rot_reg   = '0;

  // Predictor copy of the block state
  logic [5:0][15:0]   held_axes    = '0;
  logic [BTN_W-1:0]   held_buttons = '0;
  logic [1:0]         prior_grip   = '0;
  logic               grip_latch   = 1'b0;

  report_t     report_queue[$];
  sample_t     predicted_samples[$];
  int unsigned issued_reports   = 0;
  int unsigned accepted_reports = 0;
  int unsigned errors           = 0;

  six_axis_normalizer_with_grip_latch_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (in_ready),
    .s_axis_tdata  (in_data),
    .s_axis_tuser  (in_user),
    .m_axis_tvalid (out_valid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (out_data),
    .m_axis_tuser  (out_user),
    .m_axis_tlast  (out_last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Normalized Q2.14 value of output axis k under the current settings
  function automatic logic [15:0] norm_axis(int unsigned k);
    logic [SRC_W-1:0]  src;
    logic [15:0]       raw;
    logic [15:0]       res;
    logic              neg;
    longint unsigned   mag;
    longint unsigned   dv;
    longint unsigned   q;
    src = map_reg[SRC_W*k +: SRC_W];
    if (src >= AXES) return '0;
    raw = held_axes[src];
    neg = raw[15];
    mag = neg ? (65536 - longint'(raw)) : longint'(raw);
    dv  = (k < 3) ? trans_reg[DIV_W*k +: DIV_W] : rot_reg[DIV_W*(k-3) +: DIV_W];
    if (dv == 0) dv = 1;
    q = (mag * 16384) / dv;
    if (q > 16384) q = 16384;
    if (neg_reg[k]) neg = !neg;
    if (q < dz_reg) q = 0;
    res = q[15:0];
    return neg ? -res : res;
  endfunction

  function automatic sample_t raw_sample(logic [TS_W-1:0] stamp);
    sample_t s;
    s.kind    = KIND_RAW;
    s.axes    = held_axes;
    s.buttons = held_buttons;
    s.grip    = grip_latch;
    s.stamp   = stamp;
    s.last    = 1'b1;
    return s;
  endfunction

  // Latch follows a single rising edge of close or open, never both held
  function automatic void update_grip(logic [BTN_W-1:0] b);
    logic [1:0] rising;
    rising     = b[1:0] & ~prior_grip;
    prior_grip = b[1:0];
    if (!(b[GRIP_CLOSE] && b[GRIP_OPEN]) && rising[GRIP_CLOSE] != rising[GRIP_OPEN])
      grip_latch = rising[GRIP_CLOSE];
  endfunction

  function automatic void predict_results(report_t r);
    sample_t s;
    if (r.cmd == CMD_RAW) begin
      held_axes    = r.axes;
      held_buttons = r.buttons;
      update_grip(r.buttons);
      predicted_samples.push_back(raw_sample(r.stamp));
    end else begin
      s.kind = KIND_NORM;
      for (int unsigned k = 0; k < OUT_AXES; k++) s.axes[k] = norm_axis(k);
      s.buttons = '0;
      s.grip    = grip_latch;
      s.stamp   = r.stamp;
      s.last    = 1'b0;
      predicted_samples.push_back(s);
      predicted_samples.push_back(raw_sample(r.stamp));
    end
  endfunction

  // Input driver: one beat per queued report, random gaps between beats
  int unsigned in_gap   = 0;
  bit          in_burst = 1'b0;
  report_t     in_item;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_results(in_item);
        accepted_reports++;
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 4);
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (report_queue.size() != 0) begin
          in_item = report_queue.pop_front();
          in_valid <= 1'b1;
          in_data  <= {in_item.stamp, in_item.buttons, in_item.axes};
          in_user  <= in_item.cmd;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compare each beat with the oldest prediction, random stalls
  int unsigned out_stall = 0;
  bit          out_burst = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t got;
    sample_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.kind    = out_user;
        got.axes    = out_data[95:0];
        got.buttons = out_data[127:96];
        got.grip    = out_data[128];
        got.stamp   = out_data[176:129];
        got.last    = out_last;
        if (predicted_samples.size() == 0) begin
          $error("unexpected beat: kind %0d stamp %0h", got.kind, got.stamp);
          errors++;
        end else begin
          want = predicted_samples.pop_front();
          if (got.kind !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, got.kind);
            errors++;
          end
          for (int k = 0; k < 6; k++) begin
            if (got.axes[k] !== want.axes[k]) begin
              $error("out_axis_%0d: expected %0d, got %0d", k,
                     $signed(want.axes[k]), $signed(got.axes[k]));
              errors++;
            end
          end
          if (got.buttons !== want.buttons) begin
            $error("held_buttons: expected %0h, got %0h", want.buttons, got.buttons);
            errors++;
          end
          if (got.grip !== want.grip) begin
            $error("grip_closed: expected %0d, got %0d", want.grip, got.grip);
            errors++;
          end
          if (got.stamp !== want.stamp) begin
            $error("sample_time: expected %0h, got %0h", want.stamp, got.stamp);
            errors++;
          end
          if (got.last !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, got.last);
            errors++;
          end
        end
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        out_stall = out_burst ? 0 : $urandom_range(0, 4);
      end
      if (out_stall != 0) begin
        out_ready <= 1'b0;
        out_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no beat moves on any channel for too long
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic report_t raw_report(logic [5:0][15:0] axes, logic [BTN_W-1:0] btn,
                                         logic [TS_W-1:0] stamp);
    report_t r;
    r.cmd     = CMD_RAW;
    r.axes    = axes;
    r.buttons = btn;
    r.stamp   = stamp;
    return r;
  endfunction

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'($signed($urandom_range(0, 512)) - 256);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic report_t rand_report();
    report_t r;
    r.cmd = ($urandom_range(0, 9) < 4) ? CMD_TICK : CMD_RAW;
    for (int k = 0; k < 6; k++) r.axes[k] = rand_axis();
    r.buttons = $urandom();
    r.stamp   = TS_W'({$urandom(), $urandom()});
    return r;
  endfunction

  function automatic logic [SCALE_W-1:0] rand_scales();
    logic [SCALE_W-1:0] s;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 5))
        0:       s[DIV_W*k +: DIV_W] = '0;
        1:       s[DIV_W*k +: DIV_W] = 16'd1;
        2:       s[DIV_W*k +: DIV_W] = 16'hFFFF;
        3:       s[DIV_W*k +: DIV_W] = DIV_W'($urandom_range(1, 255));
        default: s[DIV_W*k +: DIV_W] = DIV_W'($urandom_range(16384, 65535));
      endcase
    end
    return s;
  endfunction

  function automatic logic [DZ_W-1:0] rand_deadzone();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return DZ_W'($urandom_range(1, 64));
      2:       return DZ_W'($urandom_range(0, 16384));
      default: return DZ_W'($urandom_range(16385, 32767));
    endcase
  endfunction

  task automatic push_report(report_t r);
    report_queue.push_back(r);
    issued_reports++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SOURCE_MAP:  map_reg   = val[MAP_W-1:0];
      REG_NEGATE:      neg_reg   = val[5:0];
      REG_DEADZONE:    dz_reg    = val[DZ_W-1:0];
      REG_SCALE_TRANS: trans_reg = val[SCALE_W-1:0];
      REG_SCALE_ROT:   rot_reg   = val[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [MAP_W-1:0] m, logic [5:0] n, logic [DZ_W-1:0] dz,
                                logic [SCALE_W-1:0] st, logic [SCALE_W-1:0] sr);
    write_reg(REG_SOURCE_MAP, CFG_DATA_W'(m));
    write_reg(REG_NEGATE, CFG_DATA_W'(n));
    write_reg(REG_DEADZONE, CFG_DATA_W'(dz));
    write_reg(REG_SCALE_TRANS, st);
    write_reg(REG_SCALE_ROT, sr);
  endtask

  // Block until every report went in and every predicted beat came out
  task automatic drain();
    while (accepted_reports != issued_reports || predicted_samples.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: axis extremes and a set of grip button transitions, reset settings
    push_report(raw_report({16'h3039, 16'h0001, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF},
                           32'h0, '0));
    push_report(rand_report());
    report_queue[$].cmd = CMD_TICK;
    report_queue[$].stamp = '1;
    push_report(raw_report({16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h0000, 16'h8000},
                           32'h1, 48'h1));
    push_report(raw_report('0, 32'h0, 48'h2));
    push_report(raw_report('0, 32'h1, 48'h3));   // close edge
    push_report(raw_report('0, 32'h3, 48'h4));   // open rises while close held
    push_report(raw_report('0, 32'h2, 48'h5));
    push_report(raw_report('0, 32'h0, 48'h6));
    push_report(raw_report('0, 32'h2, 48'h7));   // open edge
    push_report(raw_report('0, 32'h0, 48'h8));
    push_report(raw_report('0, 32'h3, 48'h9));   // both rise together
    push_report(raw_report('0, 32'h1, 48'hA));
    push_report(raw_report('0, 32'h0, 48'hB));
    push_report(raw_report('0, 32'h1, 48'hC));
    push_report(raw_report({6{16'h8000}}, 32'hFFFF_FFFC, 48'hD));
    push_report(raw_report({6{16'h7FFF}}, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
    push_report(rand_report());
    report_queue[$].cmd = CMD_TICK;
    drain();

    // Settings phases: fixed corners first, then random ones
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_settings({3'd3, 3'd2, 3'd1, 3'd0, 3'd6, 3'd7}, 6'b101010, 15'd100,
                          {16'hFFFF, 16'd1, 16'd0}, {16'd3, 16'h7FFF, 16'h8000});
        1: apply_settings('1, '1, '1, '1, '1);
        2: apply_settings('0, '0, DZ_W'(ONE_Q14), '0, '0);
        3: apply_settings(MAP_RESET, '0, '0, {3{16'h8000}}, {3{16'h8000}});
        default: begin
          logic [MAP_W-1:0] m;
          m = MAP_W'($urandom());
          apply_settings(m, 6'($urandom()), rand_deadzone(), rand_scales(), rand_scales());
        end
      endcase
      for (int i = 0; i < PHASE_LEN; i++) push_report(rand_report());
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
+incdir+hdl
hdl/sanz_pkg.sv
hdl/sanz_lane.sv
hdl/sanz_grip.sv
hdl/six_axis_normalizer_with_grip_latch_top.sv
verif/tb.sv
